/* rtl/core/sfu_pkg.sv */
// ----------------------------------------------------------------------------
// sfu_pkg
// shared types and constants of the spring force unit
// ----------------------------------------------------------------------------
package sfu_pkg;

  // default geometry of coordinates
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // spring constant is unsigned 32-bit, q16.16 when FRAC_BITS keeps its default
  localparam int K_WIDTH = 32;

  // register reset values
  localparam logic [K_WIDTH-1:0] K_RESET    = 32'd65536;
  localparam int                 REST_RESET = 65536;

  // configuration index width
  localparam int CFG_IDX_W = 3;

  // spring forms
  typedef enum logic [1:0] {
    MODE_PAIR   = 2'd0,
    MODE_ANCHOR = 2'd1,
    MODE_BUNGEE = 2'd2
  } mode_e;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE     = 3'd0,
    REG_K        = 3'd1,
    REG_REST     = 3'd2,
    REG_ANCHOR_X = 3'd3,
    REG_ANCHOR_Y = 3'd4,
    REG_ANCHOR_Z = 3'd5
  } cfg_reg_e;

endpackage

/* rtl/core/sfu_sqrt.sv */
// ----------------------------------------------------------------------------
// sfu_sqrt
// pipelined integer square root, one root bit per register stage
// ----------------------------------------------------------------------------
module sfu_sqrt
  import sfu_pkg::*;
#(
  parameter int LW     = 34,
  parameter int META_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [2*LW-1:0]   rad_i,
  input  logic [META_W-1:0] meta_i,
  output logic              valid_o,
  output logic [LW-1:0]     root_o,
  output logic [META_W-1:0] meta_o
);

  localparam int RW = LW + 3;

  logic [LW-1:0]     vld_q;
  logic [2*LW-1:0]   rad_q  [LW];
  logic [RW-1:0]     rem_q  [LW];
  logic [LW-1:0]     root_q [LW];
  logic [META_W-1:0] meta_q [LW];

  for (genvar s = 0; s < LW; s++) begin : g_stage
    logic              vld_in;
    logic [2*LW-1:0]   rad_in;
    logic [RW-1:0]     rem_in;
    logic [LW-1:0]     root_in;
    logic [META_W-1:0] meta_in;
    logic [RW-1:0]     rem_sh;
    logic [RW-1:0]     trial;
    logic              ge;

    // stage inputs
    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign meta_in = meta_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign meta_in = meta_q[s-1];
    end

    // bring down two radicand bits and try the next root bit
    assign rem_sh = {rem_in[RW-3:0], rad_in[2*LW-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[s]  <= rad_in << 2;
        rem_q[s]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[s] <= {root_in[LW-2:0], ge};
        meta_q[s] <= meta_in;
      end
    end
  end

  assign valid_o = vld_q[LW-1];
  assign root_o  = root_q[LW-1];
  assign meta_o  = meta_q[LW-1];

endmodule

/* rtl/core/sfu_div.sv */
// ----------------------------------------------------------------------------
// sfu_div
// pipelined restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module sfu_div
  import sfu_pkg::*;
#(
  parameter int NW     = 67,
  parameter int DW     = 34,
  parameter int QW     = 34,
  parameter int META_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NW-1:0]     num_i,
  input  logic [DW-1:0]     den_i,
  input  logic [META_W-1:0] meta_i,
  output logic              valid_o,
  output logic [QW-1:0]     quo_o,
  output logic [META_W-1:0] meta_o
);

  logic [QW-1:0]     vld_q;
  logic [QW-1:0]     low_q  [QW];
  logic [DW-1:0]     rem_q  [QW];
  logic [DW-1:0]     den_q  [QW];
  logic [QW-1:0]     quo_q  [QW];
  logic [META_W-1:0] meta_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic              vld_in;
    logic [QW-1:0]     low_in;
    logic [DW-1:0]     rem_in;
    logic [DW-1:0]     den_in;
    logic [QW-1:0]     quo_in;
    logic [META_W-1:0] meta_in;
    logic [DW:0]       rem_sh;
    logic [DW:0]       rem_sub;
    logic              ge;

    // upper numerator bits start as the partial remainder
    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign low_in  = num_i[QW-1:0];
      assign rem_in  = DW'(num_i[NW-1:QW]);
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign meta_in = meta_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign low_in  = low_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign meta_in = meta_q[s-1];
    end

    // shift in one numerator bit, subtract when it fits
    assign rem_sh  = {rem_in, low_in[QW-1]};
    assign ge      = (rem_sh >= {1'b0, den_in});
    assign rem_sub = rem_sh - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        low_q[s]  <= low_in << 1;
        rem_q[s]  <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        den_q[s]  <= den_in;
        quo_q[s]  <= {quo_in[QW-2:0], ge};
        meta_q[s] <= meta_in;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign meta_o  = meta_q[QW-1];

endmodule

/* rtl/core/spring_force_unit.sv */
// ----------------------------------------------------------------------------
// spring_force_unit
// hooke spring force on one particle from a partner or a fixed anchor
// ----------------------------------------------------------------------------
//  channel  | handshake                    | payload
//  ---------+------------------------------+-------------------------------
//  input    | in_valid_i  / in_stall_o     | pos_*_i, partner_*_i
//  output   | out_valid_o / out_stall_i    | force_*_o, force_applied_o
//  config   | cfg_we_i                     | cfg_idx_i, cfg_data_i
//
//  one item per cycle unless a held result stalls the pipeline; the depth is set
//  by the one-bit-per-stage square root and divider pipelines
//  the whole pipeline advances together; a held output freezes every stage
//  reset clears all valid bits and loads the register defaults
// ----------------------------------------------------------------------------
module spring_force_unit
  import sfu_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [((COORD_WIDTH > K_WIDTH) ? COORD_WIDTH : K_WIDTH)-1:0] cfg_data_i,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_y_i,
  input  logic signed [COORD_WIDTH-1:0] pos_z_i,
  input  logic signed [COORD_WIDTH-1:0] partner_x_i,
  input  logic signed [COORD_WIDTH-1:0] partner_y_i,
  input  logic signed [COORD_WIDTH-1:0] partner_z_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_WIDTH-1:0] force_x_o,
  output logic signed [COORD_WIDTH-1:0] force_y_o,
  output logic signed [COORD_WIDTH-1:0] force_z_o,
  output logic                          force_applied_o
);

  localparam int CW = COORD_WIDTH;
  localparam int MW = CW + 1;             // separation magnitude
  localparam int LW = CW + 2;             // length and stretch
  localparam int SW = 2 * LW;             // sum of squares
  localparam int PW = LW + MW;            // stretch times magnitude
  localparam int KW = K_WIDTH + LW;       // k times quotient
  localparam int HW = KW - FRAC_BITS;     // scaled force magnitude
  localparam int SQ_META_W = 3 + 3 * MW;

  // configuration registers
  logic [1:0]         mode_q;
  logic [K_WIDTH-1:0] k_q;
  logic [CW-2:0]      rest_q;
  logic [CW-1:0]      anchor_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_PAIR;
      k_q         <= K_RESET;
      rest_q      <= (CW-1)'(REST_RESET);
      anchor_q[0] <= '0;
      anchor_q[1] <= '0;
      anchor_q[2] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODE:     mode_q      <= cfg_data_i[1:0];
        REG_K:        k_q         <= cfg_data_i[K_WIDTH-1:0];
        REG_REST:     rest_q      <= cfg_data_i[CW-2:0];
        REG_ANCHOR_X: anchor_q[0] <= cfg_data_i[CW-1:0];
        REG_ANCHOR_Y: anchor_q[1] <= cfg_data_i[CW-1:0];
        REG_ANCHOR_Z: anchor_q[2] <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // global advance: the output register is free or being taken
  logic adv;
  logic out_valid_q;
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // stage 1: separation and its magnitude
  logic [CW-1:0] pos   [3];
  logic [CW-1:0] tgt   [3];
  logic [MW-1:0] d1    [3];
  logic          v1_q;
  logic [MW-1:0] mag1_q [3];
  logic [2:0]    neg1_q;

  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;
  assign tgt[0] = (mode_q == MODE_ANCHOR) ? anchor_q[0] : partner_x_i;
  assign tgt[1] = (mode_q == MODE_ANCHOR) ? anchor_q[1] : partner_y_i;
  assign tgt[2] = (mode_q == MODE_ANCHOR) ? anchor_q[2] : partner_z_i;

  for (genvar i = 0; i < 3; i++) begin : g_sep
    assign d1[i] = {pos[i][CW-1], pos[i]} - {tgt[i][CW-1], tgt[i]};
    always_ff @(posedge clk_i) begin
      if (adv) begin
        neg1_q[i] <= d1[i][MW-1];
        mag1_q[i] <= d1[i][MW-1] ? (MW'(0) - d1[i]) : d1[i];
      end
    end
  end

  // stage 2: squares
  logic            v2_q;
  logic [2*MW-1:0] sq2_q  [3];
  logic [MW-1:0]   mag2_q [3];
  logic [2:0]      neg2_q;

  for (genvar i = 0; i < 3; i++) begin : g_sq
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq2_q[i]  <= (2*MW)'(mag1_q[i]) * (2*MW)'(mag1_q[i]);
        mag2_q[i] <= mag1_q[i];
      end
    end
  end

  // stage 3: sum of squares
  logic          v3_q;
  logic [SW-1:0] sum3_q;
  logic [MW-1:0] mag3_q [3];
  logic [2:0]    neg3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      neg2_q <= neg1_q;
      neg3_q <= neg2_q;
      sum3_q <= SW'(sq2_q[0]) + SW'(sq2_q[1]) + SW'(sq2_q[2]);
      mag3_q <= mag2_q;
    end
  end

  // valid chain of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // length of the separation
  logic                 vs;
  logic [LW-1:0]        len;
  logic [SQ_META_W-1:0] sq_meta;

  sfu_sqrt #(
    .LW     (LW),
    .META_W (SQ_META_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v3_q),
    .rad_i   (sum3_q),
    .meta_i  ({neg3_q, mag3_q[2], mag3_q[1], mag3_q[0]}),
    .valid_o (vs),
    .root_o  (len),
    .meta_o  (sq_meta)
  );

  // stage a: stretch, direction and special cases
  logic [LW-1:0] rest_ext;
  logic          mode_ok;
  logic          slack;
  logic          ge_rest;
  logic          dirneg;
  logic          va_q;
  logic [LW-1:0] smag_a_q;
  logic [LW-1:0] len_a_q;
  logic [MW-1:0] mag_a_q [3];
  logic [2:0]    sn_a_q;
  logic          kill_a_q;
  logic          appl_a_q;

  assign rest_ext = LW'(rest_q);
  assign mode_ok  = (mode_q == MODE_PAIR) || (mode_q == MODE_ANCHOR) ||
                    (mode_q == MODE_BUNGEE);
  assign slack    = (mode_q == MODE_BUNGEE) && (len <= rest_ext);
  assign ge_rest  = (len >= rest_ext);
  assign dirneg   = ge_rest || (mode_q != MODE_ANCHOR);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      smag_a_q   <= ge_rest ? (len - rest_ext) : (rest_ext - len);
      len_a_q    <= len;
      mag_a_q[0] <= sq_meta[0*MW +: MW];
      mag_a_q[1] <= sq_meta[1*MW +: MW];
      mag_a_q[2] <= sq_meta[2*MW +: MW];
      sn_a_q     <= {3{dirneg}} ^ sq_meta[3*MW +: 3];
      kill_a_q   <= !mode_ok || slack || (len == '0);
      appl_a_q   <= mode_ok && !slack;
    end
  end

  // stage b: stretch times per-axis magnitude
  logic          vb_q;
  logic [PW-1:0] prod_b_q [3];
  logic [LW-1:0] len_b_q;
  logic [2:0]    sn_b_q;
  logic          kill_b_q;
  logic          appl_b_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_b_q[0] <= PW'(smag_a_q) * PW'(mag_a_q[0]);
      prod_b_q[1] <= PW'(smag_a_q) * PW'(mag_a_q[1]);
      prod_b_q[2] <= PW'(smag_a_q) * PW'(mag_a_q[2]);
      len_b_q     <= len_a_q;
      sn_b_q      <= sn_a_q;
      kill_b_q    <= kill_a_q;
      appl_b_q    <= appl_a_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (adv) begin
      va_q <= vs;
      vb_q <= va_q;
    end
  end

  // per-axis division by the length
  logic          vd;
  logic [LW-1:0] quo  [3];
  logic [2:0]    meta0;
  logic          sn1;
  logic          sn2;

  sfu_div #(
    .NW (PW), .DW (LW), .QW (LW), .META_W (3)
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vb_q),
    .num_i   (prod_b_q[0]),
    .den_i   (len_b_q),
    .meta_i  ({appl_b_q, kill_b_q, sn_b_q[0]}),
    .valid_o (vd),
    .quo_o   (quo[0]),
    .meta_o  (meta0)
  );

  sfu_div #(
    .NW (PW), .DW (LW), .QW (LW), .META_W (1)
  ) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vb_q),
    .num_i   (prod_b_q[1]),
    .den_i   (len_b_q),
    .meta_i  (sn_b_q[1]),
    .valid_o (),
    .quo_o   (quo[1]),
    .meta_o  (sn1)
  );

  sfu_div #(
    .NW (PW), .DW (LW), .QW (LW), .META_W (1)
  ) u_div_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vb_q),
    .num_i   (prod_b_q[2]),
    .den_i   (len_b_q),
    .meta_i  (sn_b_q[2]),
    .valid_o (),
    .quo_o   (quo[2]),
    .meta_o  (sn2)
  );

  // stage k: scale by the spring constant
  logic          vk_q;
  logic [KW-1:0] kp_q [3];
  logic [2:0]    sn_k_q;
  logic          kill_k_q;
  logic          appl_k_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kp_q[0]  <= KW'(k_q) * KW'(quo[0]);
      kp_q[1]  <= KW'(k_q) * KW'(quo[1]);
      kp_q[2]  <= KW'(k_q) * KW'(quo[2]);
      sn_k_q   <= {sn2, sn1, meta0[0]};
      kill_k_q <= meta0[1];
      appl_k_q <= meta0[2];
    end
  end

  // stage o: drop fraction, saturate, apply sign
  logic [CW-1:0] frc   [3];
  logic [CW-1:0] frc_q [3];
  logic          appl_q;

  for (genvar i = 0; i < 3; i++) begin : g_sat
    logic [HW-1:0] hi;
    logic [HW-1:0] lim;
    logic [HW-1:0] m;

    assign hi     = kp_q[i][KW-1:FRAC_BITS];
    assign lim    = (HW'(1) << (CW-1)) - HW'(!sn_k_q[i]);
    assign m      = (hi > lim) ? lim : hi;
    assign frc[i] = kill_k_q ? '0 :
                    (sn_k_q[i] ? (CW'(0) - m[CW-1:0]) : m[CW-1:0]);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        frc_q[i] <= frc[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      appl_q <= appl_k_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vk_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vk_q        <= vd;
      out_valid_q <= vk_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign force_x_o       = frc_q[0];
  assign force_y_o       = frc_q[1];
  assign force_z_o       = frc_q[2];
  assign force_applied_o = appl_q;

  // a slack or undefined result carries no force
  a_slack_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !force_applied_o) |->
      (force_x_o == '0 && force_y_o == '0 && force_z_o == '0))
    else $error("force present without applied flag");

  // input is held back exactly when a result waits
  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall out of step with output");

  // a held result stays valid and keeps its x force for the next cycle
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(force_x_o)))
    else $error("stalled result changed");

endmodule
